[design/sawarq_pkg.sv]
package sawarq_pkg;

    // Configuration register indexes
    localparam int unsigned CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_ACK_TIMEOUT = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_RETRIES = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_MAX_LEN     = 2'd2;
    localparam int unsigned CfgDataW = 32;

    // Reset values of the configuration registers
    localparam logic [31:0] ACK_TIMEOUT_RST = 32'd200;
    localparam logic [7:0]  MAX_RETRIES_RST = 8'd3;
    localparam logic [15:0] MAX_LEN_RST     = 16'd255;

    typedef enum logic [1:0] {
        KIND_SEND  = 2'd0,
        KIND_ACK   = 2'd1,
        KIND_POLL  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    // Sender phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_WAIT  = 3'b010,
        PH_FAULT = 3'b100
    } phase_t;

    // Link state codes as seen on the result word
    localparam logic [1:0] LINK_IDLE = 2'd0;
    localparam logic [1:0] LINK_WAIT = 2'd1;
    localparam logic [1:0] LINK_DOWN = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_ENC_ERR = 2'd2;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_NEW  = 2'd1;
    localparam logic [1:0] ACT_RETX = 2'd2;

    typedef struct packed {
        logic [31:0] ack_timeout_ms;
        logic [7:0]  max_retries;
        logic [15:0] max_payload_len;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic [7:0]  frame_type;
        logic [15:0] payload_len;
        logic [7:0]  ack_num;
    } item_t;

    typedef struct packed {
        logic [1:0]  send_status;
        logic [1:0]  link_state;
        logic [1:0]  wire_action;
        logic [7:0]  wire_seq;
        logic [7:0]  wire_type;
        logic [15:0] wire_len;
    } result_t;

endpackage

[design/sawarq_cfg.sv]
module sawarq_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [sawarq_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [sawarq_pkg::CfgDataW-1:0]    cfg_wdata,
    output sawarq_pkg::cfg_t                   cfg
);
    import sawarq_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ack_timeout_ms  <= ACK_TIMEOUT_RST;
            cfg_reg.max_retries     <= MAX_RETRIES_RST;
            cfg_reg.max_payload_len <= MAX_LEN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ACK_TIMEOUT: cfg_reg.ack_timeout_ms  <= cfg_wdata;
                CFG_MAX_RETRIES: cfg_reg.max_retries     <= cfg_wdata[7:0];
                CFG_MAX_LEN:     cfg_reg.max_payload_len <= cfg_wdata[15:0];
                default: ;  // unmapped index: dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/sawarq_core.sv]
module sawarq_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  sawarq_pkg::item_t     item,
    input  sawarq_pkg::cfg_t      cfg,
    output sawarq_pkg::result_t   result
);
    import sawarq_pkg::*;

    phase_t      phase_reg,    phase_next;
    logic [7:0]  seq_ctr_reg,  seq_ctr_next;
    logic [7:0]  cur_seq_reg,  cur_seq_next;
    logic [7:0]  retry_reg,    retry_next;
    logic [31:0] last_time_reg, last_time_next;
    logic [7:0]  held_type_reg, held_type_next;
    logic [15:0] held_len_reg,  held_len_next;

    logic [31:0] elapsed;
    logic [1:0]  status;
    logic [1:0]  action;
    kind_t       kind;

    assign kind    = kind_t'(item.kind);
    assign elapsed = item.now_ms - last_time_reg;  // wrap-safe

    always_comb begin
        phase_next     = phase_reg;
        seq_ctr_next   = seq_ctr_reg;
        cur_seq_next   = cur_seq_reg;
        retry_next     = retry_reg;
        last_time_next = last_time_reg;
        held_type_next = held_type_reg;
        held_len_next  = held_len_reg;
        status         = ST_OK;
        action         = ACT_NONE;

        unique case (kind)
            KIND_SEND: begin
                if (phase_reg != PH_IDLE) begin
                    status = ST_BUSY;
                end else if (item.payload_len > cfg.max_payload_len) begin
                    status = ST_ENC_ERR;
                end else begin
                    cur_seq_next   = seq_ctr_reg;
                    seq_ctr_next   = seq_ctr_reg + 8'd1;
                    held_type_next = item.frame_type;
                    held_len_next  = item.payload_len;
                    retry_next     = '0;
                    last_time_next = item.now_ms;
                    phase_next     = PH_WAIT;
                    action         = ACT_NEW;
                end
            end
            KIND_ACK: begin
                if (phase_reg == PH_WAIT && item.ack_num == cur_seq_reg) begin
                    phase_next = PH_IDLE;
                end
            end
            KIND_POLL: begin
                if (phase_reg == PH_WAIT && elapsed >= cfg.ack_timeout_ms) begin
                    if (retry_reg >= cfg.max_retries) begin
                        phase_next = PH_FAULT;
                    end else begin
                        retry_next     = retry_reg + 8'd1;
                        last_time_next = item.now_ms;
                        action         = ACT_RETX;
                    end
                end
            end
            KIND_CLEAR: begin
                if (phase_reg == PH_FAULT) begin
                    phase_next = PH_IDLE;
                end
            end
            default: ;
        endcase
    end

    // Result word, built from the post-event state
    always_comb begin
        result.send_status = status;
        result.wire_action = action;
        unique case (phase_next)
            PH_IDLE:  result.link_state = LINK_IDLE;
            PH_WAIT:  result.link_state = LINK_WAIT;
            PH_FAULT: result.link_state = LINK_DOWN;
            default:  result.link_state = LINK_IDLE;
        endcase
        if (action != ACT_NONE) begin
            result.wire_seq  = cur_seq_next;
            result.wire_type = held_type_next;
            result.wire_len  = held_len_next;
        end else begin
            result.wire_seq  = '0;
            result.wire_type = '0;
            result.wire_len  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            seq_ctr_reg   <= '0;
            cur_seq_reg   <= '0;
            retry_reg     <= '0;
            last_time_reg <= '0;
            held_type_reg <= '0;
            held_len_reg  <= '0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            seq_ctr_reg   <= seq_ctr_next;
            cur_seq_reg   <= cur_seq_next;
            retry_reg     <= retry_next;
            last_time_reg <= last_time_next;
            held_type_reg <= held_type_next;
            held_len_reg  <= held_len_next;
        end
    end

endmodule

[design/stop_and_wait_arq_sender_top.sv]
// Channel   Direction  Handshake          Word
// s_*       in         s_valid / s_ready  one event: kind, time, frame type, length, ack number
// m_*       out        m_valid / m_ready  one result per event: status, link state, wire command
// cfg_*     in         cfg_we only        register write, index 0..2, no read-back
//
// One word per cycle sustained while m_ready holds; the result register drives m_valid.
// The event is decoded between the input register and the result register; the
// sender state updates on the same edge the result register loads.
// Synchronous reset (aresetn low) clears both stages, sender state and registers to defaults.
// A stalled m side holds the result register; the input register still takes one
// more word, then s_ready drops until m_ready returns.
module stop_and_wait_arq_sender_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [31:0] s_now_ms,
    input  logic [7:0]  s_frame_type,
    input  logic [15:0] s_payload_len,
    input  logic [7:0]  s_ack_num,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_send_status,
    output logic [1:0]  m_link_state,
    output logic [1:0]  m_wire_action,
    output logic [7:0]  m_wire_seq,
    output logic [7:0]  m_wire_type,
    output logic [15:0] m_wire_len,

    input  logic                             cfg_we,
    input  logic [sawarq_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [sawarq_pkg::CfgDataW-1:0]  cfg_wdata
);
    import sawarq_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t step_result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;   // input word moves into the result register
    logic    s_take;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    sawarq_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg.kind        <= s_kind;
            in_item_reg.now_ms      <= s_now_ms;
            in_item_reg.frame_type  <= s_frame_type;
            in_item_reg.payload_len <= s_payload_len;
            in_item_reg.ack_num     <= s_ack_num;
        end
    end

    // Event decode and sender state
    sawarq_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_send_status = out_reg.send_status;
    assign m_link_state  = out_reg.link_state;
    assign m_wire_action = out_reg.wire_action;
    assign m_wire_seq    = out_reg.wire_seq;
    assign m_wire_type   = out_reg.wire_type;
    assign m_wire_len    = out_reg.wire_len;

endmodule
